// ===== rtl/kpt_pkg.sv =====
package kpt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 31;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned NUM_AXES = 3;
    localparam int unsigned AXIS_W = 2;

    localparam logic [REG_W-1:0] PROCESS_NOISE_RST     = 31'd655;
    localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RST = 31'd65536;
    localparam logic [REG_W-1:0] TIME_STEP_RST         = 31'd6554;
    localparam logic [DATA_W-1:0] ONE_Q16              = 32'd65536;

    localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] REG_TIME_STEP         = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PREDICT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_PROJECT = 2'd3
    } op_t;

    // datapath step selected by the controller
    typedef enum logic [3:0] {
        DP_NONE    = 4'd0,
        DP_CAPTURE = 4'd1,
        DP_MUL     = 4'd2,
        DP_ADDPOS  = 4'd3,
        DP_GAINDIV = 4'd4,
        DP_CORRMUL = 4'd5,
        DP_NEWPOS  = 4'd6,
        DP_ERRMUL  = 4'd7,
        DP_VELDIV  = 4'd8,
        DP_VELFIN  = 4'd9,
        DP_DIVSTEP = 4'd10,
        DP_LOAD    = 4'd11,
        DP_ERRADD  = 4'd12
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [AXIS_W-1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v,
                                                       output logic sat);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        begin
            mx = 66'sd2147483647;
            mn = -66'sd2147483648;
            sat = 1'b0;
            if (v > mx) begin
                sat = 1'b1;
                sat32 = 32'sh7fffffff;
            end else if (v < mn) begin
                sat = 1'b1;
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[DATA_W-1:0];
            end
        end
    endfunction

endpackage

// ===== rtl/kpt_ctrl.sv =====
module kpt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_opcode,
    output logic            m_valid,
    input  logic            m_ready,
    output kpt_pkg::dp_cmd_t cmd,
    input  kpt_pkg::dp_stat_t stat
);
    import kpt_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_AXIS  = 8'b0000_0010,
        ST_STEP  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_NEXT  = 8'b0001_0000,
        ST_OUT   = 8'b0010_0000,
        ST_WAITO = 8'b0100_0000,
        ST_SPARE = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [2:0]        phase_reg, phase_next;
    logic              mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_LOAD;
            axis_reg  <= '0;
            phase_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
            mv_reg    <= mv_next;
        end
    end

    // per-op sequence of datapath steps; phase picks the step
    function automatic dp_op_t step_of(input op_t o, input logic [2:0] ph);
        dp_op_t r;
        begin
            r = DP_NONE;
            case (o)
                OP_LOAD:    r = (ph == 3'd0) ? DP_LOAD : DP_NONE;
                OP_PREDICT: case (ph)
                    3'd0: r = DP_MUL;
                    3'd1: r = DP_ADDPOS;
                    3'd2: r = DP_ERRADD;
                    default: r = DP_NONE;
                endcase
                OP_UPDATE: case (ph)
                    3'd0: r = DP_GAINDIV;
                    3'd1: r = DP_CORRMUL;
                    3'd2: r = DP_NEWPOS;
                    3'd3: r = DP_ERRMUL;
                    3'd4: r = DP_VELDIV;
                    3'd5: r = DP_VELFIN;
                    default: r = DP_NONE;
                endcase
                OP_PROJECT: case (ph)
                    3'd0: r = DP_MUL;
                    3'd1: r = DP_ADDPOS;
                    default: r = DP_NONE;
                endcase
                default: r = DP_NONE;
            endcase
            step_of = r;
        end
    endfunction

    dp_op_t cur_step;
    assign cur_step = step_of(op_reg, phase_reg);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        mv_next    = mv_reg;
        cmd.op     = DP_NONE;
        cmd.axis   = axis_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next    = op_t'(s_opcode);
                    axis_next  = '0;
                    phase_next = '0;
                    cmd.op     = DP_CAPTURE;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.op = cur_step;
                if (cur_step == DP_NONE) begin
                    state_next = ST_NEXT;
                end else if (cur_step == DP_GAINDIV || cur_step == DP_VELDIV) begin
                    state_next = ST_DIV;
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_DIV: begin
                cmd.op = DP_DIVSTEP;
                if (stat.div_done) begin
                    phase_next = phase_reg + 3'd1;
                    state_next = ST_STEP;
                end
            end
            ST_NEXT: begin
                phase_next = '0;
                if (axis_reg == AXIS_W'(NUM_AXES - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_STEP;
                end
            end
            ST_OUT: begin
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_AXIS, ST_WAITO, ST_SPARE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/kpt_datapath.sv =====
module kpt_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kpt_pkg::dp_cmd_t                  cmd,
    output kpt_pkg::dp_stat_t                 stat,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [kpt_pkg::REG_W-1:0]         cfg_data,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_x,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_y,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_z,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vx,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vy,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vz,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_horizon,
    input  logic [1:0]                        s_opcode,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_x,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_y,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_z,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vx,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vy,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vz,
    output logic                              m_saturated
);
    import kpt_pkg::*;

    localparam int unsigned DIV_N = 48;

    logic [REG_W-1:0] q_reg, r_reg, dt_reg;
    logic signed [DATA_W-1:0] pos_reg [NUM_AXES];
    logic signed [DATA_W-1:0] vel_reg [NUM_AXES];
    logic [DATA_W-1:0]        err_reg [NUM_AXES];
    logic signed [DATA_W-1:0] a_reg [NUM_AXES];
    logic signed [DATA_W-1:0] b_reg [NUM_AXES];
    logic signed [DATA_W-1:0] hz_reg;
    logic signed [DATA_W-1:0] res_reg [NUM_AXES];
    logic                     sat_reg;
    op_t                      op_reg;
    logic signed [65:0]       prod_reg;
    logic [16:0]              k_reg;
    logic signed [DATA_W-1:0] np_reg;
    logic                     neg_reg;
    // shared restoring divider: quotient in low bits, remainder above
    logic [DIV_N-1:0]         quo_reg;
    logic [DIV_N-1:0]         rem_reg;
    logic [DIV_N-1:0]         dvs_reg;
    logic [5:0]               cnt_reg;
    logic                     dz_reg;

    logic [AXIS_W-1:0] ax;
    assign ax = cmd.axis;

    logic signed [DATA_W-1:0] p_cur, v_cur, a_cur;
    logic [DATA_W-1:0]        e_cur;
    assign p_cur = pos_reg[ax];
    assign v_cur = vel_reg[ax];
    assign e_cur = err_reg[ax];
    assign a_cur = a_reg[ax];

    logic [DIV_N-1:0] rem_sh;
    logic             rem_ge;
    assign rem_sh = {rem_reg[DIV_N-2:0], quo_reg[DIV_N-1]};
    assign rem_ge = rem_sh >= dvs_reg;
    assign stat.div_done = (cnt_reg == 6'd1);

    // gain is taken from the quotient once the gain division ends
    logic [16:0] k_now;
    assign k_now = dz_reg ? 17'd0 : quo_reg[16:0];

    logic [DATA_W:0]          e_sum;
    logic signed [65:0]       mul_a, mul_b, mul_p;
    logic signed [65:0]       sum66;
    logic signed [DATA_W-1:0] clamped;
    logic                     csat;
    logic signed [DATA_W:0]   delta;
    logic [DATA_W:0]          dabs;

    assign e_sum = {1'b0, e_cur} + {2'b0, (cmd.op == DP_ERRADD) ? q_reg : r_reg};
    assign delta = {np_reg[DATA_W-1], np_reg} - {p_cur[DATA_W-1], p_cur};
    assign dabs  = delta[DATA_W] ? $unsigned(-delta) : $unsigned(delta);

    always_comb begin
        mul_a = 66'(v_cur);
        mul_b = (op_reg == OP_PROJECT) ? 66'(hz_reg) : 66'($signed({1'b0, dt_reg}));
        if (cmd.op == DP_CORRMUL) begin
            mul_a = 66'($signed({1'b0, k_now}));
            mul_b = 66'(a_cur) - 66'(p_cur);
        end else if (cmd.op == DP_ERRMUL) begin
            mul_a = 66'($signed({1'b0, 17'(ONE_Q16) - k_reg}));
            mul_b = 66'($signed({1'b0, e_cur}));
        end
        mul_p = mul_a * mul_b;
        sum66 = 66'(p_cur) + (prod_reg >>> FRAC_W);
        if (cmd.op == DP_VELFIN) begin
            sum66 = neg_reg ? -66'($signed({1'b0, quo_reg})) : 66'($signed({1'b0, quo_reg}));
        end
        clamped = sat32(sum66, csat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg   <= PROCESS_NOISE_RST;
            r_reg   <= MEASUREMENT_NOISE_RST;
            dt_reg  <= TIME_STEP_RST;
            sat_reg <= 1'b0;
            cnt_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                err_reg[i] <= ONE_Q16;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROCESS_NOISE:     q_reg  <= cfg_data;
                    REG_MEASUREMENT_NOISE: r_reg  <= cfg_data;
                    REG_TIME_STEP:         dt_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                DP_CAPTURE: begin
                    a_reg[0] <= s_in_x;  a_reg[1] <= s_in_y;  a_reg[2] <= s_in_z;
                    b_reg[0] <= s_in_vx; b_reg[1] <= s_in_vy; b_reg[2] <= s_in_vz;
                    hz_reg   <= s_horizon;
                    op_reg   <= op_t'(s_opcode);
                    sat_reg  <= 1'b0;
                end
                DP_LOAD: begin
                    pos_reg[ax] <= a_cur;
                    vel_reg[ax] <= b_reg[ax];
                    err_reg[ax] <= {1'b0, q_reg};
                    res_reg[ax] <= a_cur;
                end
                DP_MUL, DP_CORRMUL, DP_ERRMUL: begin
                    prod_reg <= mul_p;
                end
                DP_ADDPOS: begin
                    if (op_reg == OP_PROJECT) begin
                        res_reg[ax] <= clamped;
                    end else begin
                        pos_reg[ax] <= clamped;
                        res_reg[ax] <= clamped;
                    end
                    sat_reg <= sat_reg | csat;
                end
                DP_ERRADD: begin
                    if (e_sum[DATA_W]) begin
                        err_reg[ax] <= '1;
                        sat_reg     <= 1'b1;
                    end else begin
                        err_reg[ax] <= e_sum[DATA_W-1:0];
                    end
                end
                DP_GAINDIV: begin
                    quo_reg <= DIV_N'({e_cur, 16'b0});
                    rem_reg <= '0;
                    dvs_reg <= DIV_N'(e_sum);
                    dz_reg  <= (e_sum == '0);
                    cnt_reg <= 6'(DIV_N);
                end
                DP_NEWPOS: begin
                    k_reg   <= k_now;
                    np_reg  <= clamped;
                    sat_reg <= sat_reg | csat;
                end
                DP_DIVSTEP: begin
                    cnt_reg <= cnt_reg - 6'd1;
                    rem_reg <= rem_ge ? rem_sh - dvs_reg : rem_sh;
                    quo_reg <= {quo_reg[DIV_N-2:0], rem_ge};
                end
                DP_VELDIV: begin
                    err_reg[ax] <= DATA_W'(prod_reg >>> FRAC_W);
                    pos_reg[ax] <= np_reg;
                    res_reg[ax] <= np_reg;
                    quo_reg <= DIV_N'({dabs, 16'b0});
                    rem_reg <= '0;
                    dvs_reg <= DIV_N'(dt_reg);
                    dz_reg  <= (dt_reg == '0);
                    neg_reg <= delta[DATA_W];
                    cnt_reg <= 6'(DIV_N);
                end
                DP_VELFIN: begin
                    if (dz_reg) begin
                        vel_reg[ax] <= '0;
                    end else begin
                        vel_reg[ax] <= clamped;
                        sat_reg     <= sat_reg | csat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_out_x     = res_reg[0];
    assign m_out_y     = res_reg[1];
    assign m_out_z     = res_reg[2];
    assign m_out_vx    = vel_reg[0];
    assign m_out_vy    = vel_reg[1];
    assign m_out_vz    = vel_reg[2];
    assign m_saturated = sat_reg;

endmodule

// ===== rtl/vec3_kalman_position_tracker_core.sv =====
// channel   | handshake          | payload
// s_ (in)   | s_valid / s_ready  | s_opcode, s_in_x..s_in_vz, s_horizon
// m_ (out)  | m_valid / m_ready  | m_out_x..m_out_vz, m_saturated
// cfg       | cfg_wr_en          | cfg_index, cfg_data
// one item at a time; update runs two 48-step restoring divisions per axis on
// one shared divider
// synchronous active-low reset; state, config, track, status and divider count registers take their reset values
// a held result blocks the next item until it is taken
module vec3_kalman_position_tracker_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [kpt_pkg::REG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_x,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_y,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_z,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vx,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vy,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_in_vz,
    input  logic signed [kpt_pkg::DATA_W-1:0] s_horizon,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_x,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_y,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_z,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vx,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vy,
    output logic signed [kpt_pkg::DATA_W-1:0] m_out_vz,
    output logic                              m_saturated
);
    import kpt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kpt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode,
        .m_valid, .m_ready, .cmd, .stat
    );

    kpt_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_in_x, .s_in_y, .s_in_z, .s_in_vx, .s_in_vy, .s_in_vz, .s_horizon,
        .s_opcode, .m_out_x, .m_out_y, .m_out_z, .m_out_vx, .m_out_vy,
        .m_out_vz, .m_saturated
    );

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted item while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_x) && $stable(m_saturated)))
        else $error("result changed while stalled");
    a_ready_not_with_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready) else $error("ready with result pending");

endmodule
